// ===== rtl/core/kscd_pkg.sv =====
// Shared types and constants for the key scan change detector.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package kscd_pkg;

  // Keys handled by one chained shift-register byte
  localparam int KEYS_PER_BYTE = 8;
  localparam int MAX_BYTES_DEF = 4;
  localparam int KEY_W         = 8;
  localparam int LED_W         = 32;
  localparam int LED_BYTES     = LED_W / 8;
  localparam int ACT_W         = 3;

  // Reset value of the active byte count
  localparam logic [ACT_W-1:0] ACTIVE_RST = 3'd4;

  // Command codes carried in the input tuser
  localparam logic [1:0] MODE_SCAN  = 2'd0;
  localparam logic [1:0] MODE_MAP   = 2'd1;
  localparam logic [1:0] MODE_HINT  = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  // Register select bit of the configuration address (bit 2 of paddr)
  localparam logic REG_ACTIVE = 1'b0;

  // One result item
  typedef struct packed {
    logic             is_event;
    logic [KEY_W-1:0] event_key;
    logic             event_press;
    logic             last_event;
    logic [LED_W-1:0] led_pattern;
  } kscd_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/kscd_keymap.sv =====
// Key map memory: one write port, one read port with registered read data.
// Depends on kscd_pkg for the key code width and keys per byte.
`timescale 1ns / 1ps
`default_nettype none

module kscd_keymap import kscd_pkg::*; #(
  parameter int MAX_BYTES = MAX_BYTES_DEF,
  localparam int BW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1,
  localparam int AW = BW + 3
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [KEY_W-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [KEY_W-1:0] rd_data
);

  localparam int DEPTH = MAX_BYTES * KEYS_PER_BYTE;

  logic [KEY_W-1:0] mem [DEPTH];
  logic [KEY_W-1:0] rd_data_r;

  // Write on request, read every cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/kscd_core.sv =====
// Sequencer for scan compare, map write, hint search and clear, with the
// shared map-entry compare unit and the output register.
// Depends on kscd_pkg and kscd_keymap.
`timescale 1ns / 1ps
`default_nettype none

module kscd_core import kscd_pkg::*; #(
  parameter int MAX_BYTES = MAX_BYTES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [ACT_W-1:0] active_bytes,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       in_mode,
  input  wire logic [1:0]       in_byte_index,
  input  wire logic [7:0]       in_scan_byte,
  input  wire logic [4:0]       in_map_index,
  input  wire logic [KEY_W-1:0] in_key_value,
  input  wire logic             in_press,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output kscd_res_t             out_res
);

  localparam int BW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int AW = BW + 3;
  localparam int NW = ($clog2(MAX_BYTES + 1) > ACT_W) ? $clog2(MAX_BYTES + 1) : ACT_W;
  localparam int MW = AW + 5;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SCAN_RD  = 3'd1;
  localparam logic [2:0] ST_SCAN_CHK = 3'd2;
  localparam logic [2:0] ST_FLUSH    = 3'd3;
  localparam logic [2:0] ST_HINT_RD  = 3'd4;
  localparam logic [2:0] ST_HINT_CHK = 3'd5;
  localparam logic [2:0] ST_REPORT   = 3'd6;

  // Control and state registers
  logic [2:0]       state_r, state_nxt;
  logic [7:0]       prev_r [MAX_BYTES];
  logic [7:0]       prev_nxt [MAX_BYTES];
  logic             seen_r [MAX_BYTES];
  logic             seen_nxt [MAX_BYTES];
  logic [7:0]       hint_r [MAX_BYTES];
  logic [7:0]       hint_nxt [MAX_BYTES];
  logic             pend_v_r, pend_v_nxt;
  logic             out_v_r, out_v_nxt;

  // Payload registers
  logic [BW-1:0]    bidx_r, bidx_nxt;
  logic [7:0]       diff_r, diff_nxt;
  logic [7:0]       scan_r, scan_nxt;
  logic [2:0]       bit_r, bit_nxt;
  logic [AW-1:0]    k_r, k_nxt;
  logic [KEY_W-1:0] kval_r, kval_nxt;
  logic             prs_r, prs_nxt;
  logic [KEY_W-1:0] pend_key_r, pend_key_nxt;
  logic             pend_press_r, pend_press_nxt;
  kscd_res_t        out_r, out_nxt;

  // Helpers
  logic [NW-1:0]    act_ext;
  logic [NW-1:0]    n_used;
  logic [NW-1:0]    nm1;
  logic [NW-1:0]    bidx_w;
  logic [BW-1:0]    bidx_in;
  logic             in_range;
  logic [MW-1:0]    mi_ext;
  logic             map_ok;
  logic             accept;
  logic             out_free;
  logic             wr_en;
  logic [AW-1:0]    rd_addr;
  logic [KEY_W-1:0] rd_data;
  logic             hit;
  logic             match;
  logic             adv;
  logic [BW-1:0]    hbyte;
  logic [LED_W-1:0] led_w;

  kscd_keymap #(.MAX_BYTES(MAX_BYTES)) u_keymap (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (mi_ext[AW-1:0]),
    .wr_data (in_key_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Clamp the active byte count to 1..MAX_BYTES
  assign act_ext = NW'(active_bytes);
  always_comb begin
    if (active_bytes == '0) begin
      n_used = NW'(1);
    end else if (act_ext > NW'(MAX_BYTES)) begin
      n_used = NW'(MAX_BYTES);
    end else begin
      n_used = act_ext;
    end
  end
  assign nm1 = n_used - NW'(1);

  // Decode the incoming transaction
  assign bidx_w   = NW'(in_byte_index);
  assign bidx_in  = bidx_w[BW-1:0];
  assign in_range = bidx_w < n_used;
  assign mi_ext   = MW'(in_map_index);
  assign map_ok   = mi_ext < MW'(MAX_BYTES * KEYS_PER_BYTE);

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_v_r || out_ready;
  assign wr_en    = accept && (in_mode == MODE_MAP) && map_ok;

  // Shared map read address and compare unit
  assign rd_addr = (state_r == ST_HINT_RD || state_r == ST_HINT_CHK) ? k_r : {bidx_r, bit_r};
  assign hit     = diff_r[bit_r] && (rd_data != '0);
  assign match   = (rd_data == kval_r);
  assign hbyte   = nm1[BW-1:0] - k_r[AW-1:3];

  // Pack the hint bytes into the LED word, byte zero lowest
  for (genvar b = 0; b < LED_BYTES; b++) begin : g_led
    if (b < MAX_BYTES) begin : g_on
      assign led_w[8*b +: 8] = hint_r[b];
    end else begin : g_off
      assign led_w[8*b +: 8] = '0;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    prev_nxt       = prev_r;
    seen_nxt       = seen_r;
    hint_nxt       = hint_r;
    pend_v_nxt     = pend_v_r;
    out_v_nxt      = out_v_r && !out_ready;
    bidx_nxt       = bidx_r;
    diff_nxt       = diff_r;
    scan_nxt       = scan_r;
    bit_nxt        = bit_r;
    k_nxt          = k_r;
    kval_nxt       = kval_r;
    prs_nxt        = prs_r;
    pend_key_nxt   = pend_key_r;
    pend_press_nxt = pend_press_r;
    out_nxt        = out_r;
    adv            = 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_SCAN: begin
              if (in_range) begin
                prev_nxt[bidx_in] = in_scan_byte;
                if (!seen_r[bidx_in]) begin
                  // First scan of this byte only sets the baseline
                  seen_nxt[bidx_in] = 1'b1;
                end else begin
                  diff_nxt  = prev_r[bidx_in] ^ in_scan_byte;
                  scan_nxt  = in_scan_byte;
                  bidx_nxt  = bidx_in;
                  bit_nxt   = '0;
                  state_nxt = ST_SCAN_RD;
                end
              end
            end
            MODE_HINT: begin
              kval_nxt  = in_key_value;
              prs_nxt   = in_press;
              k_nxt     = '0;
              state_nxt = ST_HINT_RD;
            end
            MODE_CLEAR: begin
              for (int b = 0; b < MAX_BYTES; b++) begin
                hint_nxt[b] = '0;
              end
              state_nxt = ST_REPORT;
            end
            default: begin
              // Map write goes straight to the memory port
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_SCAN_RD: begin
        state_nxt = ST_SCAN_CHK;
      end

      ST_SCAN_CHK: begin
        // Hold one event back so the final one can carry tlast
        if (hit) begin
          if (pend_v_r) begin
            if (out_free) begin
              out_v_nxt               = 1'b1;
              out_nxt.is_event        = 1'b1;
              out_nxt.event_key       = pend_key_r;
              out_nxt.event_press     = pend_press_r;
              out_nxt.last_event      = 1'b0;
              out_nxt.led_pattern     = led_w;
              pend_key_nxt            = rd_data;
              pend_press_nxt          = !scan_r[bit_r];
            end else begin
              adv = 1'b0;
            end
          end else begin
            pend_v_nxt     = 1'b1;
            pend_key_nxt   = rd_data;
            pend_press_nxt = !scan_r[bit_r];
          end
        end
        if (adv) begin
          if (bit_r == 3'd7) begin
            state_nxt = ST_FLUSH;
          end else begin
            bit_nxt   = bit_r + 3'd1;
            state_nxt = ST_SCAN_RD;
          end
        end
      end

      ST_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_v_nxt           = 1'b1;
          out_nxt.is_event    = 1'b1;
          out_nxt.event_key   = pend_key_r;
          out_nxt.event_press = pend_press_r;
          out_nxt.last_event  = 1'b1;
          out_nxt.led_pattern = led_w;
          pend_v_nxt          = 1'b0;
          state_nxt           = ST_IDLE;
        end
      end

      ST_HINT_RD: begin
        state_nxt = ST_HINT_CHK;
      end

      ST_HINT_CHK: begin
        // Stop at the first matching map position
        if (match) begin
          hint_nxt[hbyte][k_r[2:0]] = prs_r;
          state_nxt                 = ST_REPORT;
        end else if (k_r == {nm1[BW-1:0], 3'b111}) begin
          state_nxt = ST_REPORT;
        end else begin
          k_nxt     = k_r + AW'(1);
          state_nxt = ST_HINT_RD;
        end
      end

      ST_REPORT: begin
        if (out_free) begin
          out_v_nxt           = 1'b1;
          out_nxt.is_event    = 1'b0;
          out_nxt.event_key   = '0;
          out_nxt.event_press = 1'b0;
          out_nxt.last_event  = 1'b1;
          out_nxt.led_pattern = led_w;
          state_nxt           = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and kept state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      for (int b = 0; b < MAX_BYTES; b++) begin
        prev_r[b] <= '0;
        seen_r[b] <= 1'b0;
        hint_r[b] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      prev_r   <= prev_nxt;
      seen_r   <= seen_nxt;
      hint_r   <= hint_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    bidx_r       <= bidx_nxt;
    diff_r       <= diff_nxt;
    scan_r       <= scan_nxt;
    bit_r        <= bit_nxt;
    k_r          <= k_nxt;
    kval_r       <= kval_nxt;
    prs_r        <= prs_nxt;
    pend_key_r   <= pend_key_nxt;
    pend_press_r <= pend_press_nxt;
    out_r        <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_res   = out_r;

endmodule

`default_nettype wire

// ===== rtl/core/key_scan_change_detector.sv =====
// Key scan change detector top level: stream ports, APB register, core.
// Map write, out-of-range scan, baseline scan: core stays idle. Later scan: each key
// bit read and checked, then flush. Hint: map entries read and checked, up to 8*n
// (n = active bytes), then report. Clear: report. out_tready can stall any result.
// One transaction at a time: no input is taken until the last is done. Reset: sync
// rst_n clears scans, baselines and hint bitmap, sets active_bytes to 4; not key map.
`timescale 1ns / 1ps
`default_nettype none

module key_scan_change_detector import kscd_pkg::*; #(
  parameter int MAX_BYTES = MAX_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [1:0] byte_index, [9:2] scan_byte, [14:10] map_index, [22:15] key_value, [23] press
  input  wire logic [23:0] in_tdata,
  // [1:0] mode
  input  wire logic [1:0]  in_tuser,
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] event_key, [8] event_press, [40:9] led_pattern, [47:41] zero
  output logic [47:0]      out_tdata,
  // [0] is_event
  output logic             out_tuser,
  output logic             out_tlast,
  // Configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [ACT_W-1:0] active_r;
  logic             cfg_wr;
  kscd_res_t        res;

  // Register write and readback
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RST;
    end else if (cfg_wr && (cfg_paddr[2] == REG_ACTIVE)) begin
      active_r <= cfg_pwdata[ACT_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_ACTIVE) ? {{(32-ACT_W){1'b0}}, active_r} : '0;

  kscd_core #(.MAX_BYTES(MAX_BYTES)) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .active_bytes  (active_r),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_mode       (in_tuser),
    .in_byte_index (in_tdata[1:0]),
    .in_scan_byte  (in_tdata[9:2]),
    .in_map_index  (in_tdata[14:10]),
    .in_key_value  (in_tdata[22:15]),
    .in_press      (in_tdata[23]),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_res       (res)
  );

  // Pack the result transaction
  assign out_tdata = {7'b0, res.led_pattern, res.event_press, res.event_key};
  assign out_tuser = res.is_event;
  assign out_tlast = res.last_event;

endmodule

`default_nettype wire
